// ===== hdl/aegu_pkg.sv =====
// ----------------------------------------------------------------------------
// aegu_pkg
// shared types and constants of the auto exposure gain update core
// ----------------------------------------------------------------------------
package aegu_pkg;

  localparam int SUM_W  = 32;
  localparam int VAL_W  = 16;
  localparam int SHFT_W = 5;
  localparam int ADDR_W = 3;

  // adjustment kind reported with each result item
  typedef enum logic [1:0] {
    KIND_HOLD     = 2'd0,
    KIND_REDUCE   = 2'd1,
    KIND_INCREASE = 2'd2
  } kind_t;

  // configuration register indexes
  localparam logic [ADDR_W-1:0] REG_TARGET   = 3'd0;
  localparam logic [ADDR_W-1:0] REG_LOG2N    = 3'd1;
  localparam logic [ADDR_W-1:0] REG_MIN_EXP  = 3'd2;
  localparam logic [ADDR_W-1:0] REG_MAX_EXP  = 3'd3;
  localparam logic [ADDR_W-1:0] REG_MIN_GAIN = 3'd4;
  localparam logic [ADDR_W-1:0] REG_MAX_GAIN = 3'd5;

  // deadband half width is target / 2**BAND_SHIFT
  localparam int BAND_SHIFT = 4;

endpackage

// ===== hdl/aegu_div.sv =====
// ----------------------------------------------------------------------------
// aegu_div
// pipelined restoring divider, several lanes in lockstep, with sideband
// ----------------------------------------------------------------------------
module aegu_div #(
  parameter int NW    = 32,
  parameter int DW    = 32,
  parameter int SPS   = 2,
  parameter int LANES = 1,
  parameter int PW    = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [LANES-1:0][NW-1:0]     in_num,
  input  logic [LANES-1:0][DW-1:0]     in_den,
  input  logic [PW-1:0]                in_pay,
  output logic                         out_valid,
  output logic [LANES-1:0][NW-1:0]     out_quo,
  output logic [PW-1:0]                out_pay
);

  localparam int NST = NW / SPS;

  logic                       vld_r [NST];
  logic [LANES-1:0][DW-1:0]   rem_r [NST];
  logic [LANES-1:0][DW-1:0]   den_r [NST];
  logic [LANES-1:0][NW-1:0]   num_r [NST];
  logic [PW-1:0]              pay_r [NST];

  logic                       vld_nxt [NST];
  logic [LANES-1:0][DW-1:0]   rem_nxt [NST];
  logic [LANES-1:0][DW-1:0]   den_nxt [NST];
  logic [LANES-1:0][NW-1:0]   num_nxt [NST];
  logic [PW-1:0]              pay_nxt [NST];

  // each stage retires SPS quotient bits; quotient shifts in where the
  // numerator shifts out
  always_comb begin
    logic [DW:0]              t;
    logic [DW:0]              d;
    logic [LANES-1:0][DW-1:0] rem;
    logic [LANES-1:0][NW-1:0] num;
    for (int s = 0; s < NST; s++) begin
      if (s == 0) begin
        vld_nxt[s] = in_valid;
        den_nxt[s] = in_den;
        pay_nxt[s] = in_pay;
        rem        = '0;
        num        = in_num;
      end else begin
        vld_nxt[s] = vld_r[s-1];
        den_nxt[s] = den_r[s-1];
        pay_nxt[s] = pay_r[s-1];
        rem        = rem_r[s-1];
        num        = num_r[s-1];
      end
      for (int l = 0; l < LANES; l++) begin
        d = {1'b0, den_nxt[s][l]};
        for (int k = 0; k < SPS; k++) begin
          t         = {rem[l], num[l][NW-1]};
          num[l]    = {num[l][NW-2:0], 1'b0};
          if (t >= d) begin
            t         = t - d;
            num[l][0] = 1'b1;
          end
          rem[l] = t[DW-1:0];
        end
      end
      rem_nxt[s] = rem;
      num_nxt[s] = num;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NST; s++) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_nxt[s];
      end
      if (en) begin
        rem_r[s] <= rem_nxt[s];
        den_r[s] <= den_nxt[s];
        num_r[s] <= num_nxt[s];
        pay_r[s] <= pay_nxt[s];
      end
    end
  end

  assign out_valid = vld_r[NST-1];
  assign out_quo   = num_r[NST-1];
  assign out_pay   = pay_r[NST-1];

endmodule

// ===== hdl/auto_exposure_gain_update_core.sv =====
// ----------------------------------------------------------------------------
// auto_exposure_gain_update_core
// exposure time and gain update from frame channel sums, with deadband
// ----------------------------------------------------------------------------
// pipeline: stage a, stage b, divider 1, divider 2, then the output stage
// throughput: one item per cycle unless stalled, set by the two pipelined dividers
// stall: the whole pipeline freezes while a result waits on out_tready
// reset: synchronous active low rst_n clears all valid bits and loads
//   the configuration registers with their defaults
// ----------------------------------------------------------------------------
module auto_exposure_gain_update_core
  import aegu_pkg::*;
#(
  parameter int DIV_STEPS = 2   // quotient bits per divider stage: 1, 2, 4, 8 or 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // red_sum[31:0], green_sum[63:32], blue_sum[95:64],
  // frame_exposure[111:96], current_gain[127:112]
  input  logic [127:0]        in_tdata,
  input  logic                in_tvalid,
  output logic                in_tready,
  // next_exposure[15:0], next_gain[31:16]
  output logic [31:0]         out_tdata,
  // adjust_kind[1:0]
  output logic [1:0]          out_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  logic                cfg_we,
  input  logic [ADDR_W-1:0]   cfg_addr,
  input  logic [VAL_W-1:0]    cfg_wdata
);

  // ---------------------------------------------------------------- config
  logic [VAL_W-1:0]  target_r, min_exp_r, max_exp_r, min_gain_r, max_gain_r;
  logic [SHFT_W-1:0] log2n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r   <= 16'd128;
      log2n_r    <= 5'd18;
      min_exp_r  <= 16'd1;
      max_exp_r  <= 16'd65535;
      min_gain_r <= 16'd1;
      max_gain_r <= 16'd16;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TARGET:   target_r   <= cfg_wdata;
        REG_LOG2N:    log2n_r    <= cfg_wdata[SHFT_W-1:0];
        REG_MIN_EXP:  min_exp_r  <= cfg_wdata;
        REG_MAX_EXP:  max_exp_r  <= cfg_wdata;
        REG_MIN_GAIN: min_gain_r <= cfg_wdata;
        REG_MAX_GAIN: max_gain_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // global advance: everything moves unless a finished result is stuck
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // ------------------------------------------- stage a: sum and product
  logic             a_vld_r;
  logic [SUM_W-1:0] a_sum_r;
  logic [VAL_W-1:0] a_prod_r, a_te_r, a_g_r;
  logic [SUM_W-1:0] a_sum_nxt;
  logic [2*VAL_W-1:0] a_prod_full;

  assign a_sum_nxt   = in_tdata[31:0] + in_tdata[63:32] + in_tdata[95:64];
  assign a_prod_full = in_tdata[111:96] * in_tdata[127:112];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_tvalid;
    end
    if (adv) begin
      a_sum_r  <= a_sum_nxt;
      a_prod_r <= a_prod_full[VAL_W-1:0];   // product wraps to 16 bits
      a_te_r   <= in_tdata[111:96];
      a_g_r    <= in_tdata[127:112];
    end
  end

  // ------------------------- stage b: mean, deadband test, numerator
  logic             b_vld_r;
  logic [SUM_W-1:0] b_num_r, b_mean_r;
  kind_t            b_kind_r;
  logic [VAL_W-1:0] b_te_r, b_g_r;

  logic [SUM_W-1:0] mean_raw, mean_fix;
  logic [VAL_W:0]   band_hi, band_lo;
  logic [VAL_W-1:0] band;
  kind_t            kind_nxt;
  logic [SUM_W-1:0] num_nxt;

  always_comb begin
    mean_raw = a_sum_r >> log2n_r;
    mean_fix = (mean_raw == '0) ? SUM_W'(1) : mean_raw;   // zero mean taken as one
    band     = target_r >> BAND_SHIFT;
    band_hi  = {1'b0, target_r} + {1'b0, band};
    band_lo  = {1'b0, target_r} - {1'b0, band};
    if (mean_fix > SUM_W'(band_hi)) begin
      kind_nxt = KIND_REDUCE;
    end else if (mean_fix < SUM_W'(band_lo)) begin
      kind_nxt = KIND_INCREASE;
    end else begin
      kind_nxt = KIND_HOLD;
    end
    num_nxt = target_r * a_prod_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= a_vld_r;
    end
    if (adv) begin
      b_num_r  <= num_nxt;
      b_mean_r <= mean_fix;
      b_kind_r <= kind_nxt;
      b_te_r   <= a_te_r;
      b_g_r    <= a_g_r;
    end
  end

  // ------------------------ divider 1: scaled = target*prod / mean
  localparam int PAY_W = 2 + 2*VAL_W;

  logic               d1_vld;
  logic [SUM_W-1:0]   d1_quo;
  logic [PAY_W-1:0]   d1_pay;

  aegu_div #(
    .NW(SUM_W), .DW(SUM_W), .SPS(DIV_STEPS), .LANES(1), .PW(PAY_W)
  ) u_div_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (b_vld_r),
    .in_num   (b_num_r),
    .in_den   (b_mean_r),
    .in_pay   ({b_kind_r, b_te_r, b_g_r}),
    .out_valid(d1_vld),
    .out_quo  (d1_quo),
    .out_pay  (d1_pay)
  );

  // ---- divider 2: scaled over gain, over min time and over max time
  // the clamp quotients are formed alongside so the final pick is a mux
  logic [VAL_W-1:0]              scaled, d1_g;
  logic [2:0][VAL_W-1:0]         d2_num, d2_den;
  logic                          d2_vld;
  logic [2:0][VAL_W-1:0]         d2_quo;
  logic [PAY_W-1:0]              d2_pay;

  always_comb begin
    scaled    = d1_quo[VAL_W-1:0];   // scaled product wraps to 16 bits
    d1_g      = d1_pay[VAL_W-1:0];
    d2_num[0] = scaled;
    d2_num[1] = scaled;
    d2_num[2] = scaled;
    // a zero divisor divides by one
    d2_den[0] = (d1_g == '0)      ? VAL_W'(1) : d1_g;
    d2_den[1] = (min_exp_r == '0) ? VAL_W'(1) : min_exp_r;
    d2_den[2] = (max_exp_r == '0) ? VAL_W'(1) : max_exp_r;
  end

  aegu_div #(
    .NW(VAL_W), .DW(VAL_W), .SPS(DIV_STEPS), .LANES(3), .PW(PAY_W)
  ) u_div_time (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (d1_vld),
    .in_num   (d2_num),
    .in_den   (d2_den),
    .in_pay   (d1_pay),
    .out_valid(d2_vld),
    .out_quo  (d2_quo),
    .out_pay  (d2_pay)
  );

  // ------------------------------ output stage: clamps and gain limits
  kind_t            p_kind;
  logic [VAL_W-1:0] p_te, p_g, te_nxt, g_nxt;

  logic             out_vld_r;
  logic [VAL_W-1:0] out_te_r, out_g_r;
  kind_t            out_kind_r;

  always_comb begin
    p_kind = kind_t'(d2_pay[PAY_W-1 -: 2]);
    p_te   = d2_pay[2*VAL_W-1:VAL_W];
    p_g    = d2_pay[VAL_W-1:0];
    te_nxt = p_te;
    g_nxt  = p_g;
    case (p_kind)
      KIND_REDUCE: begin
        te_nxt = d2_quo[0];
        if (d2_quo[0] < min_exp_r) begin
          te_nxt = min_exp_r;
          g_nxt  = d2_quo[1];
        end
      end
      KIND_INCREASE: begin
        te_nxt = d2_quo[0];
        if (d2_quo[0] > max_exp_r) begin
          te_nxt = max_exp_r;
          g_nxt  = d2_quo[2];
        end
      end
      default: ;
    endcase
    // max clamp first, min wins when limits cross
    if (g_nxt > max_gain_r) g_nxt = max_gain_r;
    if (g_nxt < min_gain_r) g_nxt = min_gain_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= d2_vld;
    end
    if (adv) begin
      out_te_r   <= te_nxt;
      out_g_r    <= g_nxt;
      out_kind_r <= p_kind;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_g_r, out_te_r};
  assign out_tuser  = out_kind_r;

endmodule

// ===== dv/auto_exposure_gain_update_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// auto_exposure_gain_update_core_tb
// self-checking bench: frame sums go in, a local exposure/gain predictor
// queues the expected decision, and each result item is compared in order
// ----------------------------------------------------------------------------
module auto_exposure_gain_update_core_tb;
  import aegu_pkg::*;

  // expected decision for one frame
  typedef struct packed {
    logic [VAL_W-1:0] exposure;
    logic [VAL_W-1:0] gain;
    kind_t            kind;
  } decision_t;

  // register shadow used by the predictor
  logic [VAL_W-1:0]  target_r, min_exp_r, max_exp_r, min_gain_r, max_gain_r;
  logic [SHFT_W-1:0] log2n_r;

  // in-order scoreboard of expected decisions
  class decision_board;
    decision_t pending[$];
    int        errors;

    function void note_frame(decision_t d);
      pending.push_back(d);
    endfunction

    function void check_result(logic [31:0] data, logic [1:0] user);
      decision_t d;
      if (pending.size() == 0) begin
        $display("%0t result with nothing pending: data %h kind %0d", $realtime, data, user);
        errors++;
        return;
      end
      d = pending.pop_front();
      if (data[15:0] !== d.exposure) begin
        $display("%0t exposure expected %0d actual %0d", $realtime, d.exposure, data[15:0]);
        errors++;
      end
      if (data[31:16] !== d.gain) begin
        $display("%0t gain expected %0d actual %0d", $realtime, d.gain, data[31:16]);
        errors++;
      end
      if (user !== d.kind) begin
        $display("%0t kind expected %0d actual %0d", $realtime, d.kind, user);
        errors++;
      end
    endfunction
  endclass

  logic          clk = 0;
  logic          rst_n = 0;
  logic [127:0]  in_tdata = '0;
  logic          in_tvalid = 0;
  logic          in_tready;
  logic [31:0]   out_tdata;
  logic [1:0]    out_tuser;
  logic          out_tvalid;
  logic          out_tready = 0;
  logic          cfg_we = 0;
  logic [ADDR_W-1:0] cfg_addr = '0;
  logic [VAL_W-1:0]  cfg_wdata = '0;

  decision_board board = new();
  int  cycles = 0;
  bit  hold_off = 0;   // long receiver stall requested by the stimulus
  localparam int LATENCY = 40;
  localparam int LIMIT = 400000;

  auto_exposure_gain_update_core dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // cycle counter with timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[auto_exposure_gain_update_core] ERROR");
      $finish;
    end
  end

  // exposure/gain decision for one frame, from the register shadow
  function automatic decision_t predict_decision(logic [31:0] r, logic [31:0] g_s,
                                                 logic [31:0] b, logic [15:0] te,
                                                 logic [15:0] g);
    decision_t   d;
    logic [31:0] sum, mean;
    logic [16:0] band, hi_lim, lo_lim;
    logic [15:0] prod, scaled;
    logic [47:0] wide;
    logic [31:0] t, gn;
    sum  = r + g_s + b;
    mean = sum >> log2n_r;
    if (mean == 0) mean = 1;
    band = target_r >> BAND_SHIFT;
    hi_lim = target_r + band;
    lo_lim = target_r - band;
    t  = te;
    gn = g;
    d.kind = KIND_HOLD;
    if (mean > hi_lim || mean < lo_lim) begin
      prod   = te * g;
      wide   = 48'(target_r) * 48'(prod);
      scaled = 16'(wide / mean);
      t = scaled / ((g != 0) ? g : 16'd1);
      if (mean > hi_lim) begin
        d.kind = KIND_REDUCE;
        if (t < min_exp_r) begin
          t  = min_exp_r;
          gn = scaled / ((t != 0) ? t : 1);
        end
      end else begin
        d.kind = KIND_INCREASE;
        if (t > max_exp_r) begin
          t  = max_exp_r;
          gn = scaled / ((t != 0) ? t : 1);
        end
      end
    end
    if (gn > max_gain_r) gn = max_gain_r;
    if (gn < min_gain_r) gn = min_gain_r;
    d.exposure = t[15:0];
    d.gain     = gn[15:0];
    return d;
  endfunction

  task automatic write_reg(logic [ADDR_W-1:0] idx, logic [VAL_W-1:0] val);
    cfg_we    <= 1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 0;
    case (idx)
      REG_TARGET:   target_r   = val;
      REG_LOG2N:    log2n_r    = val[SHFT_W-1:0];
      REG_MIN_EXP:  min_exp_r  = val;
      REG_MAX_EXP:  max_exp_r  = val;
      REG_MIN_GAIN: min_gain_r = val;
      REG_MAX_GAIN: max_gain_r = val;
      default: ;
    endcase
  endtask

  task automatic load_setting(logic [15:0] tgt, logic [4:0] l2, logic [15:0] mne,
                              logic [15:0] mxe, logic [15:0] mng, logic [15:0] mxg);
    write_reg(REG_TARGET, tgt);
    write_reg(REG_LOG2N, {11'd0, l2});
    write_reg(REG_MIN_EXP, mne);
    write_reg(REG_MAX_EXP, mxe);
    write_reg(REG_MIN_GAIN, mng);
    write_reg(REG_MAX_GAIN, mxg);
  endtask

  // offer one frame item, with a random gap first
  task automatic send_frame(logic [31:0] r, logic [31:0] g_s, logic [31:0] b,
                            logic [15:0] te, logic [15:0] g);
    int gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= {g, te, b, g_s, r};
    do @(posedge clk); while (!in_tready);
    board.note_frame(predict_decision(r, g_s, b, te, g));
  endtask

  // frame whose mean lands near, above or below target at the current shift
  task automatic send_random_frame();
    logic [31:0] mean, sum, r, g_s;
    logic [15:0] te, g;
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1: mean = target_r + $urandom_range(0, target_r >> 4) - (target_r >> 5);
      2:    mean = target_r + (target_r >> 4) + $urandom_range(0, 1);
      3:    mean = target_r - (target_r >> 4) - $urandom_range(0, 1);
      4, 5: mean = $urandom_range(0, target_r);
      6, 7: mean = target_r + $urandom_range(0, 4 * target_r + 4);
      default: mean = $urandom;
    endcase
    sum = (sel == 9) ? $urandom : (mean << log2n_r) | ($urandom & ((32'd1 << log2n_r) - 1));
    r   = $urandom;
    g_s = $urandom;
    te  = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
    g   = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
    send_frame(r, g_s, sum - r - g_s, te, g);
  endtask

  // wait for every pending decision, then the pipeline latency
  task automatic drain();
    in_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    bit held;
    held = 0;
    @(posedge rst_n);
    forever begin
      if (hold_off && !held) begin
        out_tready <= 0;
        repeat (300) @(posedge clk);
        held = 1;
      end
      stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_tready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_result(out_tdata, out_tuser);
  end

  initial begin
    target_r = 128; log2n_r = 18; min_exp_r = 1; max_exp_r = 65535;
    min_gain_r = 1; max_gain_r = 16;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: field extremes and defaults
    send_frame('0, '0, '0, '0, 16'd1);               // zero mean
    send_frame('1, '1, '1, '1, '1);                  // wrapped sum
    send_frame(32'd128 << 18, 0, 0, 16'd100, 16'd4); // on target
    send_frame(32'd136 << 18, 0, 0, 16'd100, 16'd4); // upper band edge
    send_frame(32'd137 << 18, 0, 0, 16'd100, 16'd4); // just above
    send_frame(32'd120 << 18, 0, 0, 16'd100, 16'd4); // lower band edge
    send_frame(32'd119 << 18, 0, 0, 16'd100, 16'd4); // just below
    send_frame(32'd1 << 18, 0, 0, 16'd255, 16'd255); // scaled product wraps
    send_frame(32'd200 << 18, 0, 0, 16'd50, 16'd0);  // zero gain
    send_frame(32'd10 << 18, 0, 0, 16'd50, 16'd0);   // zero gain increase
    send_frame(32'd4000 << 18, 0, 0, 16'd2, 16'd3);  // reduce below min time
    drain();

    // zero clamp time and crossed gain limits
    load_setting(16'd1000, 5'd0, 16'd65535, 16'd0, 16'd40, 16'd3);
    send_frame(32'd10, 0, 0, 16'd300, 16'd7);
    send_frame(32'd1000, 0, 0, 16'd300, 16'd7);
    send_frame(32'd5000, 0, 0, 16'd300, 16'd7);
    send_frame(32'hFFFF_FFFF, 0, 0, 16'hFFFF, 16'hFFFF);
    drain();

    // extreme settings, the defaults, then random settings
    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0: load_setting(16'd1, 5'd31, 16'd1, 16'd1, 16'd1, 16'd1);
        1: load_setting(16'd65535, 5'd0, 16'd65535, 16'd65535, 16'd65535, 16'd65535);
        2: load_setting(16'd128, 5'd18, 16'd1, 16'd65535, 16'd1, 16'd16);
        default: load_setting(16'($urandom_range(1, 4000)), 5'($urandom_range(0, 20)),
                              16'($urandom_range(1, 50)), 16'($urandom_range(50, 65535)),
                              16'($urandom_range(1, 4)), 16'($urandom_range(4, 300)));
      endcase
      for (int k = 0; k < 150; k++) begin
        if (phase == 4 && k == 10) hold_off = 1;  // fill the pipeline
        send_random_frame();
      end
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0)
      $display("[auto_exposure_gain_update_core] OK");
    else
      $display("[auto_exposure_gain_update_core] ERROR");
    $finish;
  end

endmodule
